FILE: rtl/core/btd_pkg.sv
// Shared constants and types for the binary to padded decimal ASCII converter.
`timescale 1ns / 1ps

package btd_pkg;

  // Field widths
  localparam int VALUE_W    = 31;
  localparam int MIN_W      = 5;
  localparam int CHAR_W     = 6;

  // Longest output string and the decimal digits a value can produce
  localparam int MAX_DIGITS = 16;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * 4;

  // Counter and index widths
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int STEP_W     = $clog2(VALUE_W);

  // Job queue between the converter and the emitter
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // One finished conversion: digits least significant first, zero padded
  typedef struct packed {
    logic [MAX_DIGITS-1:0][3:0] digits;
    logic [CNT_W-1:0]           count;
  } btd_job_t;

endpackage

FILE: rtl/core/btd_in_if.sv
// Input channel: value and minimum digit count with valid/ready.
`timescale 1ns / 1ps

interface btd_in_if import btd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [MIN_W-1:0]   min_digits;

  modport source (output valid, output value, output min_digits, input ready);
  modport sink   (input valid, input value, input min_digits, output ready);
endinterface

FILE: rtl/core/btd_out_if.sv
// Result channel: one ASCII digit per transaction with a last flag.
`timescale 1ns / 1ps

interface btd_out_if import btd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

FILE: rtl/core/btd_front.sv
// Front end: accepts a value and converts it to BCD by shift-and-add-3.
`timescale 1ns / 1ps

module btd_front import btd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [MIN_W-1:0]   in_min_digits,
  output logic               job_valid,
  input  logic               job_ready,
  output btd_job_t           job
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} front_state_t;

  front_state_t       state_r, state_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [CNT_W-1:0]   want_r, want_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   min_ext;
  logic [CNT_W-1:0]   used_digits;

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Widen the requested width to the counter width; it is saturated at the longest string on accept
  assign min_ext = CNT_W'(in_min_digits);

  // Find the highest non-zero digit; zero still takes one digit
  always_comb begin
    used_digits = CNT_W'(1);
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        used_digits = CNT_W'(i + 1);
      end
    end
  end

  // Build the job from the finished BCD word
  always_comb begin
    job.digits = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      job.digits[i] = bcd_r[4*i +: 4];
    end
    job.count = (used_digits > want_r) ? used_digits : want_r;
  end

  assign in_ready  = (state_r == F_IDLE);
  assign job_valid = (state_r == F_PUSH);

  // Sequencer: load, shift VALUE_W times, hand over
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    want_nxt  = want_r;
    step_nxt  = step_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          bin_nxt   = in_value;
          bcd_nxt   = '0;
          want_nxt  = (min_ext > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : min_ext;
          step_nxt  = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(VALUE_W - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (job_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    want_r <= want_nxt;
  end

endmodule

FILE: rtl/core/btd_queue.sv
// Short job queue between the converter and the character emitter.
`timescale 1ns / 1ps

module btd_queue import btd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  btd_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output btd_job_t pop_job
);

  btd_job_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              do_push, do_pop;

  assign push_ready = (fill_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - QCNT_W'(1);
      end
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/btd_back.sv
// Back end: emits a job's digits as ASCII, most significant first.
`timescale 1ns / 1ps

module btd_back import btd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  btd_job_t          job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_digit_char,
  output logic              out_last
);

  logic                  busy_r;
  btd_job_t              job_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     char_r;
  logic                  last_r;
  logic                  slot_free;
  logic [3:0]            cur_digit;

  assign job_ready      = !busy_r;
  assign slot_free      = !out_valid_r || out_ready;
  assign cur_digit      = job_r.digits[idx_r];
  assign out_valid      = out_valid_r;
  assign out_digit_char = char_r;
  assign out_last       = last_r;

  // Take a job, then walk its digits down into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Refill the output register, or drop it once the transaction is taken
      if (busy_r && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (!busy_r) begin
        if (job_valid) begin
          busy_r <= 1'b1;
        end
      end else if (slot_free && (idx_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Payload: job copy, digit index and character
  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (job_valid) begin
        job_r <= job;
        idx_r <= IDX_W'(job.count - CNT_W'(1));
      end
    end else if (slot_free) begin
      char_r <= ASCII_ZERO + CHAR_W'(cur_digit);
      last_r <= (idx_r == '0);
      idx_r  <= idx_r - IDX_W'(1);
    end
  end

endmodule

FILE: rtl/core/binary_to_padded_decimal_ascii.sv
// Converts a 31-bit binary value into zero-padded decimal ASCII characters.
// Each input transaction carries a value and a minimum digit count (saturated
// at 16); the block returns one character transaction per digit, most
// significant first, with last set on the final one. Zero gives '0'. The front
// end accepts a value, runs 31 shift-and-add-3 steps and hands the job to the
// queue before it takes the next value; the back end emits one character per
// cycle within a value while the receiver is ready, and the two-entry job queue
// lets the front end convert the next value while the back end still emits.
`timescale 1ns / 1ps

module binary_to_padded_decimal_ascii import btd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  btd_in_if.sink   in_if,
  btd_out_if.source out_if
);

  logic     fq_valid, fq_ready;
  btd_job_t fq_job;
  logic     qb_valid, qb_ready;
  btd_job_t qb_job;

  // Convert
  btd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_value      (in_if.value),
    .in_min_digits (in_if.min_digits),
    .job_valid     (fq_valid),
    .job_ready     (fq_ready),
    .job           (fq_job)
  );

  // Buffer finished jobs
  btd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  // Emit characters
  btd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (qb_valid),
    .job_ready      (qb_ready),
    .job            (qb_job),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_digit_char (out_if.digit_char),
    .out_last       (out_if.last)
  );

endmodule

FILE: rtl/core/btd_checker.sv
// Port-level checks for the decimal ASCII converter, bound to the top level.
`timescale 1ns / 1ps

module btd_checker import btd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_digit_char,
  input logic              out_last
);

  // Every character is a decimal digit
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= ASCII_ZERO) && (out_digit_char <= ASCII_ZERO + CHAR_W'(9)))
    else $error("character outside '0'..'9'");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // The converter is busy right after taking a value
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after a transaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_digit_char) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind binary_to_padded_decimal_ascii btd_checker u_btd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_digit_char (out_if.digit_char),
  .out_last       (out_if.last)
);

FILE: tb/sv/tb_binary_to_padded_decimal_ascii.sv
// Self-checking testbench for the binary to padded decimal ASCII converter.
`timescale 1ns / 1ps

module tb_binary_to_padded_decimal_ascii;
  import btd_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [MIN_W-1:0]   min_digits;
  } conv_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } ascii_char_t;

  localparam int STALL_PCT_LOW  = 16;
  localparam int STALL_PCT_HIGH = 84;
  localparam int MAX_SHOWN      = 20;
  localparam int DRAIN_CYCLES   = 60;

  logic clk;
  logic rst_n;

  btd_in_if  in_if ();
  btd_out_if out_if ();

  binary_to_padded_decimal_ascii dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  conv_req_t   pending_reqs[$];
  ascii_char_t expected_chars[$];

  int total_reqs;
  int accepted_reqs;
  int checked_chars;
  int mismatch_count;
  int send_stall_pct;
  int recv_stall_pct;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous bound on the whole run
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Count a mismatch, print only the first few
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
  endtask

  // Work out the characters one conversion must produce and queue them
  function automatic void queue_decimal_chars(input logic [VALUE_W-1:0] val,
                                              input logic [MIN_W-1:0]   min_n);
    logic [3:0]  digs[MAX_DIGITS];
    int unsigned rest;
    int unsigned want;
    int unsigned n;
    int          k;
    ascii_char_t c;
    rest = val;
    want = (min_n > MAX_DIGITS) ? MAX_DIGITS : min_n;
    n    = 0;
    // form digits, least significant first
    do begin
      digs[n] = 4'(rest % 10);
      n++;
      rest = rest / 10;
    end while (rest != 0 && n < MAX_DIGITS);
    // pad with zeros up to the minimum count
    while (n < want) begin
      digs[n] = 4'd0;
      n++;
    end
    // emit most significant first
    for (k = int'(n) - 1; k >= 0; k--) begin
      c.digit_char = ASCII_ZERO + CHAR_W'(digs[k]);
      c.last       = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic add_req(input logic [VALUE_W-1:0] val, input logic [MIN_W-1:0] min_n);
    conv_req_t r;
    r.value      = val;
    r.min_digits = min_n;
    pending_reqs.push_back(r);
  endtask

  // Random value: boundaries of powers of ten, short and full-width values, all ones or zero
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned pow10[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                               10000000, 100000000, 1000000000};
    int unsigned p;
    case ($urandom_range(0, 9))
      0, 1, 2, 9: return VALUE_W'($urandom);
      3, 4: begin
        p = pow10[$urandom_range(0, 9)];
        return VALUE_W'(p - 1 + $urandom_range(0, 2));
      end
      5, 6: return VALUE_W'($urandom_range(0, 999));
      7: return VALUE_W'($urandom) >> $urandom_range(0, VALUE_W - 1);
      default: return ($urandom_range(0, 1) == 1) ? {VALUE_W{1'b1}} : '0;
    endcase
  endfunction

  function automatic logic [MIN_W-1:0] pick_min_digits();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return '0;
    if (sel < 75) return MIN_W'($urandom_range(0, 12));
    return MIN_W'($urandom_range(13, 31));
  endfunction

  // Stall mix per phase: sender light / receiver heavy, then swapped, then none
  always_comb begin
    if (accepted_reqs * 3 < total_reqs) begin
      send_stall_pct = STALL_PCT_LOW;
      recv_stall_pct = STALL_PCT_HIGH;
    end else if (accepted_reqs * 3 < total_reqs * 2) begin
      send_stall_pct = STALL_PCT_HIGH;
      recv_stall_pct = STALL_PCT_LOW;
    end else begin
      send_stall_pct = 0;
      recv_stall_pct = 0;
    end
  end

  // Driver: predict on each accepted transaction, then offer the next request
  always @(posedge clk) begin
    conv_req_t r;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        queue_decimal_chars(in_if.value, in_if.min_digits);
        accepted_reqs <= accepted_reqs + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_stall_pct) begin
          r = pending_reqs.pop_front();
          in_if.valid      <= 1'b1;
          in_if.value      <= r.value;
          in_if.min_digits <= r.min_digits;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each character with the oldest expectation
  always @(posedge clk) begin
    ascii_char_t want_c;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%0h last=%0b",
                                    out_if.digit_char, out_if.last));
        end else begin
          want_c = expected_chars.pop_front();
          checked_chars <= checked_chars + 1;
          if (out_if.digit_char !== want_c.digit_char) begin
            report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
                                      out_if.digit_char, want_c.digit_char));
          end
          if (out_if.last !== want_c.last) begin
            report_mismatch($sformatf("last %0b, expected %0b",
                                      out_if.last, want_c.last));
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int i;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.value       = '0;
    in_if.min_digits  = '0;
    out_if.ready      = 1'b0;
    accepted_reqs     = 0;
    checked_chars     = 0;
    mismatch_count    = 0;

    // zero, with and without padding, including saturated minimum counts
    add_req('0, 5'd0);
    add_req('0, 5'd1);
    add_req('0, 5'd2);
    add_req('0, 5'd16);
    add_req('0, 5'd17);
    add_req('0, 5'd31);
    // largest value: minimum below, equal to and above its own length
    add_req({VALUE_W{1'b1}}, 5'd0);
    add_req({VALUE_W{1'b1}}, 5'd10);
    add_req({VALUE_W{1'b1}}, 5'd11);
    add_req({VALUE_W{1'b1}}, 5'd16);
    add_req({VALUE_W{1'b1}}, 5'd31);
    // digit-count boundaries
    add_req(31'd9, 5'd0);
    add_req(31'd10, 5'd0);
    add_req(31'd99, 5'd1);
    add_req(31'd100, 5'd3);
    add_req(31'd999999999, 5'd9);
    add_req(31'd1000000000, 5'd4);
    // minimum smaller and larger than needed, and mixed bit patterns
    add_req(31'd1234567890, 5'd5);
    add_req(31'd5, 5'd3);
    add_req(31'h2AAAAAAA, 5'd12);
    add_req(31'h55555555, 5'd21);
    add_req(31'd7, 5'd15);

    for (i = 0; i < 480; i++) begin
      add_req(pick_value(), pick_min_digits());
    end
    total_reqs = pending_reqs.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all requests to go in and all characters to come out
    while (pending_reqs.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values (zero, full 31-bit range, minimum counts 0..31),",
             accepted_reqs);
    $display("checked %0d characters under mixed sender and receiver stalls.",
             checked_chars);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
